// ===== sv/avs_pkg.sv =====
// Shared constants, op codes and saturation functions of the velocity servo PID.
// No dependencies.
`timescale 1ns / 1ps
package avs_pkg;
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SEED = 2'd1;
    localparam logic [1:0] OP_INIT = 2'd2;

    localparam logic [2:0] REG_GAIN  = 3'd0;
    localparam logic [2:0] REG_IFAC  = 3'd1;
    localparam logic [2:0] REG_FF    = 3'd2;
    localparam logic [2:0] REG_DTIME = 3'd3;
    localparam logic [2:0] REG_FRIC  = 3'd4;
    localparam logic [2:0] REG_LIMIT = 3'd5;
    localparam logic [2:0] REG_LOPOS = 3'd6;
    localparam logic [2:0] REG_HIPOS = 3'd7;

    localparam int unsigned DT_MIN = 1678;
    localparam int unsigned QBITS  = 32;   // quotient bits of derivative divide

    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        if (v > 80'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -80'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [79:0] v);
        if (v > 80'(MAX48)) return MAX48;
        if (v < 80'(MIN48)) return MIN48;
        return v[47:0];
    endfunction
endpackage

// ===== sv/avs_divider.sv =====
// Restoring divider: 71-bit dividend by 24-bit divisor, QBITS quotient bits, one per cycle.
// Flags a quotient that does not fit in QBITS bits. Depends on avs_pkg.
`timescale 1ns / 1ps
module avs_divider
    import avs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [70:0]      i_num,
    input  logic [23:0]      i_den,
    output logic             o_done,
    output logic             o_ovf,
    output logic [QBITS-1:0] o_quot
);
    logic [QBITS-1:0] r_quot, n_quot;
    logic [23:0] r_rem, n_rem;
    logic [23:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy;
    logic        r_ovf;
    logic [24:0] w_trial, w_diff;

    always_comb begin
        w_trial = {r_rem, r_quot[QBITS-1]};
        w_diff  = w_trial - {1'b0, r_den};
        n_rem   = w_trial[23:0];
        n_quot  = {r_quot[QBITS-2:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem     = w_diff[23:0];
            n_quot[0] = 1'b1;
        end
        n_cnt = r_cnt - 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(QBITS);
        end else if (r_busy) begin
            r_cnt <= n_cnt;
            if (n_cnt == 6'd0) r_busy <= 1'b0;
        end
    end

    // high part of the dividend is the first partial remainder; if it reaches
    // the divisor the quotient needs more than QBITS bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num[QBITS-1:0];
            r_rem  <= i_num[QBITS+23:QBITS];
            r_den  <= i_den;
            r_ovf  <= i_num[70:QBITS] >= {{(47-QBITS){1'b0}}, i_den};
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_busy && (r_cnt == 6'd1);
    assign o_quot = n_quot;
    assign o_ovf  = r_ovf;
endmodule

// ===== sv/axis_velocity_servo_pid.sv =====
// Top level of the velocity servo PID: sequencer, shared multiplier, state.
// Depends on avs_pkg and avs_divider.
`timescale 1ns / 1ps
//  channel   direction  payload
//  s_axis    in         tuser: op; tdata: measured_position, velocity_setpoint,
//                       time_step, axis_driven, seed_position
//  m_axis    out        tdata: drive_value, position_echo, position_out_of_range
//  cfg       in         i_cfg_we / i_cfg_index / i_cfg_data, one register per write
// A derivative tick: reference, error, integral low/high, integral term, numerator,
// divide (start plus 32 quotient bits), sum/gain/feedforward, result, idle. A step
// below DT_MIN skips the divide; undriven tick: reference, result; other ops: result.
// Reset is synchronous and clears state and registers to their defaults.
// The input is not ready while a request is in work or its result is unread.
module axis_velocity_servo_pid
    import avs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] op
    input  logic [1:0]   s_axis_tuser,
    // [31:0] measured_position, [63:32] velocity_setpoint, [87:64] time_step,
    // [88] axis_driven, [120:89] seed_position, rest zero
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] drive_value, [63:32] position_echo, [64] position_out_of_range
    output logic [71:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_REF   = 12'b000000000010,
        S_ERR   = 12'b000000000100,
        S_INTL  = 12'b000000001000,
        S_INTH  = 12'b000000010000,
        S_ITRM  = 12'b000000100000,
        S_DNUM  = 12'b000001000000,
        S_DDIV  = 12'b000010000000,
        S_SUM   = 12'b000100000000,
        S_GAIN  = 12'b001000000000,
        S_FF    = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state;

    logic [30:0] r_gain, r_ifac, r_ff, r_dtime, r_fric, r_limit;
    logic signed [31:0] r_lopos, r_hipos;

    logic signed [47:0] r_ref, r_integ;
    logic signed [31:0] r_last;
    logic r_homed, r_started;

    logic signed [31:0] r_meas, r_sp;
    logic [23:0] r_dt;
    logic r_driven;

    logic signed [47:0] r_err;
    logic signed [31:0] r_eterm, r_iterm, r_dterm, r_inner;
    logic signed [79:0] r_acc;
    logic r_dneg;
    logic r_oor;
    logic signed [31:0] r_drive_o;

    // shared multiplier
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_REF:  begin w_ma = {r_sp[31], r_sp}; w_mb = {9'd0, r_dt}; end
            S_INTL: begin w_ma = {9'd0, r_err[23:0]}; w_mb = {9'd0, r_dt}; end
            S_INTH: begin w_ma = 33'($signed(r_err[47:24])); w_mb = {9'd0, r_dt}; end
            S_ITRM: begin w_ma = {2'b0, r_ifac}; w_mb = {r_acc[31], r_acc[31:0]}; end
            S_DNUM: begin w_ma = {2'b0, r_dtime};
                w_mb = 33'(r_last) - 33'(r_meas); end
            S_GAIN: begin w_ma = {2'b0, r_gain}; w_mb = {r_inner[31], r_inner}; end
            S_FF:   begin w_ma = {2'b0, r_ff}; w_mb = {r_sp[31], r_sp}; end
            default: ;
        endcase
        w_prod = w_ma * w_mb;
    end

    // derivative divider; its start pulse is registered together with the numerator
    logic             r_div_go;
    logic             w_div_done, w_div_ovf;
    logic [QBITS-1:0] w_quot;
    logic [62:0]      w_num_abs;
    assign w_num_abs = r_acc[63] ? 63'(-r_acc[63:0]) : r_acc[62:0];

    avs_divider u_ddiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num({w_num_abs, 8'd0}), .i_den(r_dt),
        .o_done(w_div_done), .o_ovf(w_div_ovf), .o_quot(w_quot)
    );

    logic signed [79:0] w_ref_sum, w_int_sum, w_isat, w_q, w_fbase, w_fsum, w_lim;
    logic signed [79:0] w_fric, w_limit;
    logic w_sign_neg;

    assign w_fric  = {49'd0, r_fric};
    assign w_limit = {49'd0, r_limit};

    always_comb begin
        w_ref_sum = 80'(r_ref) + 80'(w_prod >>> 8);
        w_int_sum = 80'(r_integ) + 80'(w_prod) + r_acc;
        w_isat    = 80'(sat48(w_int_sum) >>> 16);
        w_q       = r_dneg ? -80'(w_quot) : 80'(w_quot);
        w_fbase   = r_acc + 80'(w_prod >>> 16);
        if (r_last < r_meas) w_sign_neg = 1'b0;
        else if (r_last > r_meas) w_sign_neg = 1'b1;
        else w_sign_neg = w_fbase[79];
        w_fsum = w_sign_neg ? w_fbase - w_fric : w_fbase + w_fric;
        if (w_fsum > w_limit) w_lim = w_limit;
        else if (w_fsum < -w_limit) w_lim = -w_limit;
        else w_lim = w_fsum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 31'd65536; r_ifac <= '0; r_ff <= 31'd65536; r_dtime <= '0;
            r_fric <= '0; r_limit <= '0;
            r_lopos <= 32'sh8000_0000; r_hipos <= 32'sh7FFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GAIN:  r_gain  <= i_cfg_data[30:0];
                REG_IFAC:  r_ifac  <= i_cfg_data[30:0];
                REG_FF:    r_ff    <= i_cfg_data[30:0];
                REG_DTIME: r_dtime <= i_cfg_data[30:0];
                REG_FRIC:  r_fric  <= i_cfg_data[30:0];
                REG_LIMIT: r_limit <= i_cfg_data[30:0];
                REG_LOPOS: r_lopos <= i_cfg_data;
                REG_HIPOS: r_hipos <= i_cfg_data;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ref <= '0; r_integ <= '0; r_last <= '0;
            r_homed <= 1'b0; r_started <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= (r_state == S_DNUM);
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_meas   <= (s_axis_tuser == OP_TICK) ? s_axis_tdata[31:0] : '0;
                    r_sp     <= s_axis_tdata[63:32];
                    r_dt     <= r_started ? s_axis_tdata[87:64] : 24'd0;
                    r_driven <= s_axis_tdata[88];
                    if (s_axis_tuser == OP_TICK) begin
                        r_started <= 1'b1;
                        r_state   <= S_REF;
                    end else begin
                        if (s_axis_tuser == OP_SEED || s_axis_tuser == OP_INIT) begin
                            r_ref  <= {s_axis_tdata[120:89], 16'd0};
                            r_last <= s_axis_tdata[120:89];
                            if (s_axis_tuser == OP_INIT) r_homed <= 1'b1;
                        end
                        r_drive_o <= '0;
                        r_oor     <= 1'b0;
                        r_state   <= S_OUT;
                    end
                end
                S_REF: begin
                    r_oor <= r_homed && (r_meas < r_lopos || r_meas > r_hipos);
                    if (r_driven) begin
                        r_ref   <= sat48(w_ref_sum);
                        r_state <= S_ERR;
                    end else begin
                        r_drive_o <= '0;
                        r_last    <= r_meas;
                        r_state   <= S_OUT;
                    end
                end
                S_ERR: begin
                    r_err   <= sat48(80'(r_ref) - (80'(r_meas) <<< 16));
                    r_state <= S_INTL;
                end
                S_INTL: begin
                    r_acc   <= 80'(w_prod >>> 24);
                    r_eterm <= sat32(80'(r_err >>> 16));
                    r_state <= S_INTH;
                end
                S_INTH: begin
                    r_integ <= sat48(w_int_sum);
                    r_acc   <= 80'(sat32(w_isat));
                    r_state <= S_ITRM;
                end
                S_ITRM: begin
                    r_iterm <= sat32(80'(w_prod >>> 16));
                    r_dterm <= '0;
                    r_state <= (r_dt < 24'(DT_MIN)) ? S_SUM : S_DNUM;
                end
                S_DNUM: begin
                    r_acc   <= 80'(w_prod);
                    r_dneg  <= w_prod[65];
                    r_state <= S_DDIV;
                end
                S_DDIV: if (w_div_done) begin
                    // quotient is floor(|num|*256/dt): truncation toward zero
                    if (w_div_ovf) r_dterm <= r_dneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    else r_dterm <= sat32(w_q);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_inner <= sat32(80'(r_eterm) + 80'(r_iterm) + 80'(r_dterm));
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_acc   <= 80'(w_prod >>> 16);
                    r_state <= S_FF;
                end
                S_FF: begin
                    r_drive_o <= w_lim[31:0];
                    r_last    <= r_meas;
                    r_state   <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {7'd0, r_oor, r_meas, r_drive_o};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DDIV) |-> r_dt >= 24'(DT_MIN))
        else $error("divide with short step");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_homed |-> !r_oor)
        else $error("range flag while not homed");
endmodule
